/* hdl/plt_pkg.sv */
// Shared types, codes and constants for the trajectory table.
package plt_pkg;

   localparam int Q16_W = 32;
   localparam int FRAC_BITS = 16;
   localparam int MAT_W = 8;
   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 3;
   localparam int SEG_COUNT_W = 7;
   localparam int DEF_MAX_SEGMENTS = 64;

   typedef logic signed [Q16_W-1:0] q16_type;

   typedef enum logic [OPCODE_W-1:0] {
      OP_CREATE    = 3'd0,
      OP_SET_STATE = 3'd1,
      OP_SET_POS   = 3'd2,
      OP_SET_VEL   = 3'd3,
      OP_QUERY     = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_APPENDED   = 3'd0,
      ST_REPLACED   = 3'd1,
      ST_UNCHANGED  = 3'd2,
      ST_EARLY      = 3'd3,
      ST_QEARLY     = 3'd4,
      ST_FULL       = 3'd5,
      ST_NOTCREATED = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SEARCH,
      S_CALC,
      S_EVENT,
      S_RESP
   } state_type;

   // One motion segment as stored in the table
   typedef struct packed {
      q16_type              t_start;
      q16_type              pos_x;
      q16_type              pos_y;
      q16_type              pos_z;
      q16_type              vel_x;
      q16_type              vel_y;
      q16_type              vel_z;
      logic [MAT_W-1:0]     mat;
   } seg_entry_type;

endpackage

/* hdl/plt_if.sv */
// Request and response channel interfaces of the trajectory table.
interface plt_req_if import plt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   q16_type             at_time;
   q16_type             pos_x;
   q16_type             pos_y;
   q16_type             pos_z;
   q16_type             vel_x;
   q16_type             vel_y;
   q16_type             vel_z;
   logic [MAT_W-1:0]    material_id;

   modport source (output valid, opcode, at_time, pos_x, pos_y, pos_z,
                   vel_x, vel_y, vel_z, material_id, input ready);
   modport sink (input valid, opcode, at_time, pos_x, pos_y, pos_z,
                 vel_x, vel_y, vel_z, material_id, output ready);
endinterface

interface plt_rsp_if import plt_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   q16_type                out_x;
   q16_type                out_y;
   q16_type                out_z;
   logic [SEG_COUNT_W-1:0] segment_count;

   modport source (output valid, status, out_x, out_y, out_z, segment_count,
                   input ready);
   modport sink (input valid, status, out_x, out_y, out_z, segment_count,
                 output ready);
endinterface

/* hdl/plt_adv_unit.sv */
// Shared two-stage unit: pos + floor(elapsed * vel / 2^16), saturated.
module plt_adv_unit import plt_pkg::*; (
   input  logic             clock,
   input  logic [Q16_W-1:0] el,
   input  q16_type          vel,
   input  q16_type          pos,
   output q16_type          result
);

   localparam int PROD_W = 2 * Q16_W + 1;
   localparam int QUOT_W = PROD_W - FRAC_BITS;
   localparam int SUM_W = QUOT_W + 1;

   logic signed [PROD_W-1:0] prod_ff;
   q16_type                  pos_ff;
   q16_type                  result_ff;
   logic signed [QUOT_W-1:0] quot;
   logic signed [SUM_W-1:0]  sum;
   q16_type                  sat;

   // Stage one: full product of unsigned elapsed time and signed velocity
   always_ff @(posedge clock) begin
      prod_ff <= $signed({1'b0, el}) * vel;
      pos_ff  <= pos;
   end

   // Drop the fraction (floor), add the start position, clamp to 32 bits
   always_comb begin
      quot = $signed(prod_ff[PROD_W-1:FRAC_BITS]);
      sum  = $signed({quot[QUOT_W-1], quot})
             + $signed({{(SUM_W-Q16_W){pos_ff[Q16_W-1]}}, pos_ff});
      if (sum[SUM_W-1:Q16_W-1] == '0 || sum[SUM_W-1:Q16_W-1] == '1) begin
         sat = sum[Q16_W-1:0];
      end else if (sum[SUM_W-1]) begin
         sat = {1'b1, {(Q16_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(Q16_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= sat;
   end

   assign result = result_ff;

endmodule

/* hdl/piecewise_linear_trajectory_table_core.sv */
// Trajectory table top level: segment store, sequencer and response register.
//
// Holds up to MAX_SEGMENTS motion segments in a single-port-read memory and
// handles one request at a time; req_ch.ready is high only while idle, and
// each request yields exactly one response. A create request is answered from
// the decode state; a set state or set position request passes the event compare
// first. A query or set velocity scans the stored segments through the memory
// read port, one segment per cycle, then runs x, y and z through one shared
// multiply and saturating add unit; set velocity then also passes the event
// compare. The response is held until it is taken, and ready returns in the
// cycle after the response is taken.
module piecewise_linear_trajectory_table_core import plt_pkg::*; #(
   parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
   input  logic     clock,
   input  logic     reset,
   plt_req_if.sink   req_ch,
   plt_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(MAX_SEGMENTS);
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam logic [2:0] STEP_X = 3'd2;
   localparam logic [2:0] STEP_Y = 3'd3;
   localparam logic [2:0] STEP_Z = 3'd4;

   state_type     state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   q16_type       creation_ff, creation_in;
   opcode_type    op_ff, op_in;
   seg_entry_type item_ff, item_in;
   seg_entry_type last_ff, last_in;
   seg_entry_type hit_ff, hit_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic          chk_ff, chk_in;
   logic [2:0]    step_ff, step_in;
   status_type    status_ff, status_in;
   q16_type       out_x_ff, out_x_in;
   q16_type       out_y_ff, out_y_in;
   q16_type       out_z_ff, out_z_in;

   seg_entry_type seg_mem [MAX_SEGMENTS];
   seg_entry_type rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic          wr_en;
   logic [IDX_W-1:0] wr_addr;
   seg_entry_type wr_data;

   logic [Q16_W-1:0] unit_el;
   q16_type       unit_vel;
   q16_type       unit_pos;
   q16_type       unit_res;

   // Segment memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         seg_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= seg_mem[rd_addr];
   end

   plt_adv_unit u_adv (
      .clock  (clock),
      .el     (unit_el),
      .vel    (unit_vel),
      .pos    (unit_pos),
      .result (unit_res)
   );

   // Elapsed time is never negative and below 2^32, so the low word is exact
   assign unit_el = item_ff.t_start - hit_ff.t_start;

   // Feed one axis per cycle into the shared unit
   always_comb begin
      case (step_ff)
         3'd0: begin
            unit_vel = hit_ff.vel_x;
            unit_pos = hit_ff.pos_x;
         end
         3'd1: begin
            unit_vel = hit_ff.vel_y;
            unit_pos = hit_ff.pos_y;
         end
         default: begin
            unit_vel = hit_ff.vel_z;
            unit_pos = hit_ff.pos_z;
         end
      endcase
   end

   assign req_ch.ready = (state_ff == S_IDLE);
   assign rsp_ch.valid = (state_ff == S_RESP);
   assign rsp_ch.status = status_ff;
   assign rsp_ch.out_x = out_x_ff;
   assign rsp_ch.out_y = out_y_ff;
   assign rsp_ch.out_z = out_z_ff;
   assign rsp_ch.segment_count = SEG_COUNT_W'(count_ff);

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      creation_in = creation_ff;
      op_in       = op_ff;
      item_in     = item_ff;
      last_in     = last_ff;
      hit_in      = hit_ff;
      issue_in    = issue_ff;
      chk_in      = chk_ff;
      step_in     = step_ff;
      status_in   = status_ff;
      out_x_in    = out_x_ff;
      out_y_in    = out_y_ff;
      out_z_in    = out_z_ff;
      rd_addr     = issue_ff[IDX_W-1:0];
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = item_ff;

      unique case (state_ff)
         S_IDLE: begin
            // Capture the request
            if (req_ch.valid) begin
               op_in           = opcode_type'(req_ch.opcode);
               item_in.t_start = req_ch.at_time;
               item_in.pos_x   = req_ch.pos_x;
               item_in.pos_y   = req_ch.pos_y;
               item_in.pos_z   = req_ch.pos_z;
               item_in.vel_x   = req_ch.vel_x;
               item_in.vel_y   = req_ch.vel_y;
               item_in.vel_z   = req_ch.vel_z;
               item_in.mat     = req_ch.material_id;
               state_in        = S_DECODE;
            end
         end

         S_DECODE: begin
            out_x_in = '0;
            out_y_in = '0;
            out_z_in = '0;
            state_in = S_RESP;
            unique case (op_ff) inside
               OP_CREATE: begin
                  // Restart the history with one segment at rest
                  wr_data       = item_ff;
                  wr_data.vel_x = '0;
                  wr_data.vel_y = '0;
                  wr_data.vel_z = '0;
                  wr_en         = 1'b1;
                  wr_addr       = '0;
                  last_in       = wr_data;
                  count_in      = CNT_W'(1);
                  creation_in   = item_ff.t_start;
                  status_in     = ST_APPENDED;
               end
               OP_SET_STATE: begin
                  if (count_ff == '0) begin
                     status_in = ST_NOTCREATED;
                  end else begin
                     item_in.mat = last_ff.mat;
                     state_in    = S_EVENT;
                  end
               end
               OP_SET_POS: begin
                  if (count_ff == '0) begin
                     status_in = ST_NOTCREATED;
                  end else begin
                     item_in.vel_x = last_ff.vel_x;
                     item_in.vel_y = last_ff.vel_y;
                     item_in.vel_z = last_ff.vel_z;
                     item_in.mat   = last_ff.mat;
                     state_in      = S_EVENT;
                  end
               end
               OP_SET_VEL, OP_QUERY: begin
                  if (count_ff == '0) begin
                     status_in = ST_NOTCREATED;
                  end else if ($signed(item_ff.t_start) < $signed(creation_ff)) begin
                     status_in = (op_ff == OP_QUERY) ? ST_QEARLY : ST_EARLY;
                  end else begin
                     issue_in = '0;
                     chk_in   = 1'b0;
                     state_in = S_SEARCH;
                  end
               end
               default: begin
                  status_in = ST_UNCHANGED;
               end
            endcase
         end

         S_SEARCH: begin
            // Issue one read per cycle and keep the last segment not after the time
            if (issue_ff < count_ff) begin
               issue_in = issue_ff + CNT_W'(1);
               chk_in   = 1'b1;
            end else begin
               chk_in = 1'b0;
            end
            if (chk_ff && $signed(item_ff.t_start) >= $signed(rd_data_ff.t_start)) begin
               hit_in = rd_data_ff;
            end
            if (issue_ff == count_ff && !chk_ff) begin
               step_in  = '0;
               state_in = S_CALC;
            end
         end

         S_CALC: begin
            // Collect x, y, z from the shared unit after its product and result registers
            step_in = step_ff + 3'd1;
            if (step_ff == STEP_X) begin
               out_x_in = unit_res;
            end
            if (step_ff == STEP_Y) begin
               out_y_in = unit_res;
            end
            if (step_ff == STEP_Z) begin
               if (op_ff == OP_QUERY) begin
                  out_z_in  = unit_res;
                  status_in = ST_UNCHANGED;
                  state_in  = S_RESP;
               end else begin
                  item_in.pos_x = out_x_ff;
                  item_in.pos_y = out_y_ff;
                  item_in.pos_z = unit_res;
                  item_in.mat   = last_ff.mat;
                  out_x_in      = '0;
                  out_y_in      = '0;
                  out_z_in      = '0;
                  state_in      = S_EVENT;
               end
            end
         end

         S_EVENT: begin
            // Compare with the latest segment: drop, reject, replace or append
            state_in = S_RESP;
            wr_data  = item_ff;
            if (item_ff == last_ff) begin
               status_in = ST_UNCHANGED;
            end else if ($signed(item_ff.t_start) < $signed(last_ff.t_start)) begin
               status_in = ST_EARLY;
            end else if (item_ff.t_start == last_ff.t_start) begin
               wr_en     = 1'b1;
               wr_addr   = IDX_W'(count_ff - CNT_W'(1));
               last_in   = item_ff;
               status_in = ST_REPLACED;
            end else if (count_ff >= CNT_W'(MAX_SEGMENTS)) begin
               status_in = ST_FULL;
            end else begin
               wr_en     = 1'b1;
               wr_addr   = IDX_W'(count_ff);
               last_in   = item_ff;
               count_in  = count_ff + CNT_W'(1);
               status_in = ST_APPENDED;
            end
         end

         S_RESP: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         creation_ff <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         creation_ff <= creation_in;
      end
   end

   // Payload and sequencing registers
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      item_ff   <= item_in;
      last_ff   <= last_in;
      hit_ff    <= hit_in;
      issue_ff  <= issue_in;
      chk_ff    <= chk_in;
      step_ff   <= step_in;
      status_ff <= status_in;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      out_z_ff  <= out_z_in;
   end

endmodule

/* hdl/plt_checker.sv */
// Port-level assertions for the trajectory table, bound to the top level.
module plt_checker import plt_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [STATUS_W-1:0]    status,
   input q16_type                out_x,
   input q16_type                out_y,
   input q16_type                out_z,
   input logic [SEG_COUNT_W-1:0] segment_count
);

   // One request in flight: never take a request while a response waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");

   // A taken request closes the request side at once
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready stayed high after a request");

   // Exactly one response per request
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> !rsp_valid)
      else $error("response repeated");

   // Only an unchanged-status response, such as a successful query, may carry a position
   a_zero_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status != ST_UNCHANGED) |->
      (out_x == '0 && out_y == '0 && out_z == '0))
      else $error("position on a non-query response");

   // Not created means an empty table
   a_not_created: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status == ST_NOTCREATED) |-> (segment_count == '0))
      else $error("not-created status with stored segments");

endmodule

bind piecewise_linear_trajectory_table_core plt_checker u_plt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .status        (rsp_ch.status),
   .out_x         (rsp_ch.out_x),
   .out_y         (rsp_ch.out_y),
   .out_z         (rsp_ch.out_z),
   .segment_count (rsp_ch.segment_count)
);
